@@ rtl/assert_macros.svh @@
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every clock edge outside reset
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error(msg);

// property checked on every clock edge, reset included
`define ASSERT_CLK_ALL(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

@@ rtl/srie_pkg.sv @@
`default_nettype none

package srie_pkg;

    // depths are powers of two; REG_COUNT may be any value in its range
    localparam int REG_COUNT     = 32;
    localparam int STACK_DEPTH   = 256;
    localparam int PROGRAM_DEPTH = 1024;

    localparam int REG_AW   = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;
    localparam int STACK_AW = $clog2(STACK_DEPTH);
    localparam int SP_W     = $clog2(STACK_DEPTH + 1);
    localparam int IP_W     = $clog2(PROGRAM_DEPTH);

    localparam int DATA_W     = 32;
    localparam int S_TDATA_W  = 72;
    localparam int M_TDATA_W  = 64;

    typedef enum logic [2:0] {
        CMD_PUSH = 3'd0,
        CMD_POP  = 3'd1,
        CMD_SET  = 3'd2,
        CMD_GOTO = 3'd3,
        CMD_HALT = 3'd4
    } cmd_t;

    typedef enum logic [1:0] {
        MODE_COPY   = 2'd0,
        MODE_IMM    = 2'd1,
        MODE_REG_RR = 2'd2,
        MODE_REG_RI = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        ALU_ADD  = 3'd0,
        ALU_SUB  = 3'd1,
        ALU_EQ   = 3'd2,
        ALU_GT   = 3'd3,
        ALU_GTE  = 3'd4,
        ALU_LT   = 3'd5,
        ALU_LTE  = 3'd6,
        ALU_NONE = 3'd7
    } alu_op_t;

    typedef enum logic [2:0] {
        ST_RUN       = 3'd0,
        ST_HALT      = 3'd1,
        ST_OVERFLOW  = 3'd2,
        ST_UNDERFLOW = 3'd3,
        ST_BAD_CMD   = 3'd4
    } status_t;

    // register field modulo REG_COUNT, as a table over the 32 field codes
    function automatic logic [REG_AW-1:0] reg_idx(input logic [4:0] r);
        logic [REG_AW-1:0] res;
        res = '0;
        for (int i = 0; i < 32; i++) begin
            if (r == 5'(i)) begin
                res = REG_AW'(i % REG_COUNT);
            end
        end
        return res;
    endfunction

    function automatic logic [4:0] reg_field(input logic [REG_AW-1:0] r);
        logic [REG_AW+4:0] t;
        t = {5'b0, r};
        return t[4:0];
    endfunction

    function automatic logic [IP_W-1:0] ip_from_target(input logic [9:0] t);
        logic [IP_W+9:0] w;
        w = {{IP_W{1'b0}}, t};
        return w[IP_W-1:0];
    endfunction

    function automatic logic [9:0] ip_field(input logic [IP_W-1:0] ip);
        logic [IP_W+9:0] w;
        w = {10'b0, ip};
        return w[9:0];
    endfunction

    function automatic logic [8:0] depth_field(input logic [SP_W-1:0] sp);
        logic [SP_W+8:0] w;
        w = {9'b0, sp};
        return w[8:0];
    endfunction

endpackage

`default_nettype wire

@@ rtl/srie_ram.sv @@
`default_nettype none

module srie_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  wire logic                             clk,
    input  wire logic                             we,
    input  wire logic [$clog2(DEPTH)-1:0]         waddr,
    input  wire logic [WIDTH-1:0]                 wdata,
    input  wire logic                             re,
    input  wire logic [$clog2(DEPTH)-1:0]         raddr,
    output logic      [WIDTH-1:0]                 rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // read returns the old contents on a same-address write
    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

@@ rtl/stack_register_instruction_executor.sv @@
// path: input transaction, then the execute stage registers (s1_*), then the output register
// throughput: one instruction per cycle, back to back, unless the output stalls; the
//   register file and stack memories are read on accept and written on execute, with forwarding
// reset: synchronous, active low; clears stack pointer, instruction pointer, stop flag
//   and the register valid flags (registers read as zero until written)
// stack contents are undefined after reset and need no clearing pass
`default_nettype none

module stack_register_instruction_executor
    import srie_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    // cmd[2:0], mode[4:3], alu_op[7:5], dest_reg[12:8], src_reg[17:13],
    // src2_reg[22:18], immediate[54:23], jump_target[64:55], zero fill
    input  wire logic [S_TDATA_W-1:0] s_tdata,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    // next_ip[9:0], status[12:10], reg_written[13], written_reg[18:14],
    // written_value[50:19], stack_depth[59:51], zero fill
    output logic [M_TDATA_W-1:0]      m_tdata
);

`include "assert_macros.svh"

    logic accept;
    logic fire1;

    // execute stage
    logic                s1_valid_reg;
    logic [2:0]          s1_cmd_reg;
    logic [1:0]          s1_mode_reg;
    logic [2:0]          s1_op_reg;
    logic [REG_AW-1:0]   s1_rd_reg;
    logic [REG_AW-1:0]   s1_rs_reg;
    logic [REG_AW-1:0]   s1_rt_reg;
    logic [DATA_W-1:0]   s1_imm_reg;
    logic [IP_W-1:0]     s1_target_reg;

    // architectural state
    logic [SP_W-1:0]     sp_reg;
    logic [SP_W-1:0]     sp_next;
    logic [IP_W-1:0]     ip_reg;
    logic [IP_W-1:0]     ip_next;
    logic                stopped_reg;
    logic                stopped_next;
    status_t             stop_code_reg;
    status_t             stop_code_next;
    logic [REG_COUNT-1:0] reg_valid_reg;

    // last writes, for read-during-write forwarding
    logic                lastw_valid_reg;
    logic [REG_AW-1:0]   lastw_addr_reg;
    logic [DATA_W-1:0]   lastw_data_reg;
    logic                slast_valid_reg;
    logic [STACK_AW-1:0] slast_addr_reg;
    logic [DATA_W-1:0]   slast_data_reg;

    // memory ports
    logic [DATA_W-1:0]   ra_rdata;
    logic [DATA_W-1:0]   rb_rdata;
    logic [DATA_W-1:0]   st_rdata;
    logic [REG_AW-1:0]   in_rs;
    logic [REG_AW-1:0]   in_rt;
    logic [SP_W-1:0]     sp_rd_dec;
    logic [SP_W-1:0]     sp_pop_dec;
    logic [STACK_AW-1:0] pop_addr;

    // execute results
    logic [DATA_W-1:0]   op_a;
    logic [DATA_W-1:0]   op_rt;
    logic [DATA_W-1:0]   op_b;
    logic [DATA_W-1:0]   top_val;
    logic [DATA_W-1:0]   alu_res;
    logic                alu_ok;
    status_t             status;
    logic                wr;
    logic [DATA_W-1:0]   wval;
    logic [IP_W-1:0]     nxt;
    logic                do_push;
    logic                do_pop;
    logic [DATA_W-1:0]   push_val;

    logic                m_tvalid_reg;
    logic [M_TDATA_W-1:0] m_tdata_reg;

    assign fire1    = s1_valid_reg && (!m_tvalid_reg || m_tready);
    assign s_tready = !s1_valid_reg || fire1;
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    assign in_rs      = reg_idx(s_tdata[17:13]);
    assign in_rt      = reg_idx(s_tdata[22:18]);
    // top-of-stack address from the stack pointer the incoming instruction will see
    assign sp_rd_dec  = sp_next - SP_W'(1);
    assign sp_pop_dec = sp_reg - SP_W'(1);
    assign pop_addr   = sp_pop_dec[STACK_AW-1:0];

    srie_ram #(.WIDTH(DATA_W), .DEPTH(REG_COUNT)) u_reg_a (
        .clk   (aclk),
        .we    (fire1 && wr),
        .waddr (s1_rd_reg),
        .wdata (wval),
        .re    (accept),
        .raddr (in_rs),
        .rdata (ra_rdata)
    );

    srie_ram #(.WIDTH(DATA_W), .DEPTH(REG_COUNT)) u_reg_b (
        .clk   (aclk),
        .we    (fire1 && wr),
        .waddr (s1_rd_reg),
        .wdata (wval),
        .re    (accept),
        .raddr (in_rt),
        .rdata (rb_rdata)
    );

    srie_ram #(.WIDTH(DATA_W), .DEPTH(STACK_DEPTH)) u_stack (
        .clk   (aclk),
        .we    (fire1 && do_push),
        .waddr (sp_reg[STACK_AW-1:0]),
        .wdata (push_val),
        .re    (accept),
        .raddr (sp_rd_dec[STACK_AW-1:0]),
        .rdata (st_rdata)
    );

    // operand selection with forwarding and never-written registers as zero
    always_comb begin
        if (lastw_valid_reg && lastw_addr_reg == s1_rs_reg) begin
            op_a = lastw_data_reg;
        end else if (reg_valid_reg[s1_rs_reg]) begin
            op_a = ra_rdata;
        end else begin
            op_a = '0;
        end
        if (lastw_valid_reg && lastw_addr_reg == s1_rt_reg) begin
            op_rt = lastw_data_reg;
        end else if (reg_valid_reg[s1_rt_reg]) begin
            op_rt = rb_rdata;
        end else begin
            op_rt = '0;
        end
        if (slast_valid_reg && slast_addr_reg == pop_addr) begin
            top_val = slast_data_reg;
        end else begin
            top_val = st_rdata;
        end
        op_b     = (s1_mode_reg == MODE_REG_RR) ? op_rt : s1_imm_reg;
        push_val = (s1_mode_reg == MODE_IMM) ? s1_imm_reg : op_a;
    end

    always_comb begin
        alu_ok = 1'b1;
        case (s1_op_reg)
            ALU_ADD: alu_res = op_a + op_b;
            ALU_SUB: alu_res = op_a - op_b;
            ALU_EQ:  alu_res = {31'b0, op_a == op_b};
            ALU_GT:  alu_res = {31'b0, op_a > op_b};
            ALU_GTE: alu_res = {31'b0, op_a >= op_b};
            ALU_LT:  alu_res = {31'b0, op_a < op_b};
            ALU_LTE: alu_res = {31'b0, op_a <= op_b};
            default: begin
                alu_res = '0;
                alu_ok  = 1'b0;
            end
        endcase
    end

    always_comb begin
        status  = ST_RUN;
        wr      = 1'b0;
        wval    = '0;
        nxt     = ip_reg + IP_W'(1);
        do_push = 1'b0;
        do_pop  = 1'b0;
        if (stopped_reg) begin
            nxt    = ip_reg;
            status = stop_code_reg;
        end else begin
            case (s1_cmd_reg)
                CMD_PUSH: begin
                    if (sp_reg == SP_W'(STACK_DEPTH)) begin
                        status = ST_OVERFLOW;
                    end else begin
                        do_push = 1'b1;
                    end
                end
                CMD_POP: begin
                    if (sp_reg == '0) begin
                        status = ST_UNDERFLOW;
                    end else begin
                        do_pop = 1'b1;
                        wr     = 1'b1;
                        wval   = top_val;
                    end
                end
                CMD_SET: begin
                    case (s1_mode_reg)
                        MODE_COPY: begin
                            wr   = 1'b1;
                            wval = op_a;
                        end
                        MODE_IMM: begin
                            wr   = 1'b1;
                            wval = s1_imm_reg;
                        end
                        default: begin
                            wr   = alu_ok;
                            wval = alu_res;
                        end
                    endcase
                end
                CMD_GOTO: begin
                    if (op_a != '0) begin
                        nxt = s1_target_reg;
                    end
                end
                CMD_HALT: status = ST_HALT;
                default:  status = ST_BAD_CMD;
            endcase
            if (status != ST_RUN) begin
                nxt = ip_reg;
            end
        end
    end

    always_comb begin
        sp_next        = sp_reg;
        ip_next        = ip_reg;
        stopped_next   = stopped_reg;
        stop_code_next = stop_code_reg;
        if (fire1 && !stopped_reg) begin
            if (do_push) begin
                sp_next = sp_reg + SP_W'(1);
            end else if (do_pop) begin
                sp_next = sp_pop_dec;
            end
            ip_next = nxt;
            if (status != ST_RUN) begin
                stopped_next   = 1'b1;
                stop_code_next = status;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg    <= 1'b0;
            m_tvalid_reg    <= 1'b0;
            sp_reg          <= '0;
            ip_reg          <= '0;
            stopped_reg     <= 1'b0;
            stop_code_reg   <= ST_RUN;
            reg_valid_reg   <= '0;
            lastw_valid_reg <= 1'b0;
            slast_valid_reg <= 1'b0;
        end else begin
            sp_reg        <= sp_next;
            ip_reg        <= ip_next;
            stopped_reg   <= stopped_next;
            stop_code_reg <= stop_code_next;
            if (accept) begin
                s1_valid_reg <= 1'b1;
            end else if (fire1) begin
                s1_valid_reg <= 1'b0;
            end
            if (fire1) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            if (fire1 && wr) begin
                reg_valid_reg[s1_rd_reg] <= 1'b1;
                lastw_valid_reg          <= 1'b1;
            end
            if (fire1 && do_push) begin
                slast_valid_reg <= 1'b1;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_cmd_reg    <= s_tdata[2:0];
            s1_mode_reg   <= s_tdata[4:3];
            s1_op_reg     <= s_tdata[7:5];
            s1_rd_reg     <= reg_idx(s_tdata[12:8]);
            s1_rs_reg     <= in_rs;
            s1_rt_reg     <= in_rt;
            s1_imm_reg    <= s_tdata[54:23];
            s1_target_reg <= ip_from_target(s_tdata[64:55]);
        end
        if (fire1 && wr) begin
            lastw_addr_reg <= s1_rd_reg;
            lastw_data_reg <= wval;
        end
        if (fire1 && do_push) begin
            slast_addr_reg <= sp_reg[STACK_AW-1:0];
            slast_data_reg <= push_val;
        end
        if (fire1) begin
            m_tdata_reg <= {4'b0, depth_field(sp_next), wval,
                            wr ? reg_field(s1_rd_reg) : 5'b0, wr,
                            3'(status), ip_field(nxt)};
        end
    end

    `ASSERT_CLK(a_sp_range, sp_reg <= SP_W'(STACK_DEPTH), "stack pointer beyond depth")
    `ASSERT_CLK(a_stop_holds, stopped_reg |=> stopped_reg && $stable(ip_reg) && $stable(sp_reg),
        "state changed while stopped")
    `ASSERT_CLK(a_exec_to_out, fire1 |=> m_tvalid_reg, "executed instruction lost")
    `ASSERT_CLK_ALL(a_one_stack_op, !(do_push && do_pop), "push and pop together")

endmodule

`default_nettype wire

@@ dv/stack_register_instruction_executor_tb.sv @@
`default_nettype none

module stack_register_instruction_executor_tb;
    import srie_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [2:0] BAD_CMD_LO  = 3'd5;
    localparam logic [2:0] BAD_CMD_HI  = 3'd7;
    localparam int         QUIET_TAIL  = 150;
    localparam int         DRAIN_WAIT  = 20;
    localparam int         RANDOM_ITEMS = 1810;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;

    stack_register_instruction_executor uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    logic [S_TDATA_W-1:0] instr_queue[$];
    logic [M_TDATA_W-1:0] expected_results[$];
    int                   instr_total;
    int                   instrs_accepted = 0;
    int                   results_seen = 0;
    int                   errors = 0;
    int                   gen_depth = 0;

    // predictor state
    logic [DATA_W-1:0] arch_regs [REG_COUNT];
    logic [DATA_W-1:0] stack_mem [STACK_DEPTH];
    logic [8:0]        sp = '0;
    logic [9:0]        ip = '0;
    logic              halted = 1'b0;
    status_t           stop_code = ST_RUN;

    initial begin
        for (int i = 0; i < REG_COUNT; i++) begin
            arch_regs[i] = '0;
        end
    end

    function automatic logic [M_TDATA_W-1:0] execute_instr(input logic [S_TDATA_W-1:0] w);
        logic [2:0]        cmd;
        logic [1:0]        mode;
        logic [2:0]        op;
        logic [4:0]        rd;
        logic [4:0]        rs;
        logic [4:0]        rt;
        logic [31:0]       imm;
        logic [9:0]        tgt;
        logic [9:0]        nxt;
        logic [DATA_W-1:0] a;
        logic [DATA_W-1:0] b;
        logic [DATA_W-1:0] wval;
        logic              wr;
        status_t           st;
        cmd  = w[2:0];
        mode = w[4:3];
        op   = w[7:5];
        rd   = 5'(int'(w[12:8]) % REG_COUNT);
        rs   = 5'(int'(w[17:13]) % REG_COUNT);
        rt   = 5'(int'(w[22:18]) % REG_COUNT);
        imm  = w[54:23];
        tgt  = 10'(int'(w[64:55]) % PROGRAM_DEPTH);
        nxt  = 10'((int'(ip) + 1) % PROGRAM_DEPTH);
        st   = ST_RUN;
        wr   = 1'b0;
        wval = '0;
        if (halted) begin
            nxt = ip;
            st  = stop_code;
        end else begin
            case (cmd)
                CMD_PUSH: begin
                    if (sp >= 9'(STACK_DEPTH)) begin
                        st = ST_OVERFLOW;
                    end else begin
                        stack_mem[sp[STACK_AW-1:0]] = (mode == MODE_IMM) ? imm : arch_regs[rs];
                        sp = sp + 9'd1;
                    end
                end
                CMD_POP: begin
                    if (sp == '0) begin
                        st = ST_UNDERFLOW;
                    end else begin
                        sp   = sp - 9'd1;
                        wval = stack_mem[sp[STACK_AW-1:0]];
                        wr   = 1'b1;
                    end
                end
                CMD_SET: begin
                    a = arch_regs[rs];
                    b = (mode == MODE_REG_RR) ? arch_regs[rt] : imm;
                    wr = 1'b1;
                    case (mode)
                        MODE_COPY: wval = a;
                        MODE_IMM:  wval = imm;
                        default: begin
                            case (op)
                                ALU_ADD: wval = a + b;
                                ALU_SUB: wval = a - b;
                                ALU_EQ:  wval = DATA_W'(a == b);
                                ALU_GT:  wval = DATA_W'(a > b);
                                ALU_GTE: wval = DATA_W'(a >= b);
                                ALU_LT:  wval = DATA_W'(a < b);
                                ALU_LTE: wval = DATA_W'(a <= b);
                                default: wr = 1'b0;
                            endcase
                        end
                    endcase
                end
                CMD_GOTO: begin
                    if (arch_regs[rs] != '0) begin
                        nxt = tgt;
                    end
                end
                CMD_HALT: st = ST_HALT;
                default:  st = ST_BAD_CMD;
            endcase
            if (wr) begin
                arch_regs[rd] = wval;
            end
            if (st != ST_RUN) begin
                halted    = 1'b1;
                stop_code = st;
                nxt       = ip;
            end else begin
                ip = nxt;
            end
        end
        if (!wr) begin
            wval = '0;
            rd   = '0;
        end
        return {4'b0, sp, wval, rd, wr, 3'(st), nxt};
    endfunction

    task automatic queue_instr(input logic [2:0] cmd, input logic [1:0] mode,
                               input logic [2:0] op, input logic [4:0] rd,
                               input logic [4:0] rs, input logic [4:0] rt,
                               input logic [31:0] imm, input logic [9:0] tgt);
        instr_queue.push_back({7'b0, tgt, imm, rt, rs, rd, op, mode, cmd});
        if (cmd == CMD_PUSH) begin
            gen_depth++;
        end else if (cmd == CMD_POP) begin
            gen_depth--;
        end
    endtask

    function automatic logic [31:0] pick_imm();
        case ($urandom_range(0, 3))
            0:       return $urandom_range(0, 3);
            1:       return 32'hFFFF_FFFF - $urandom_range(0, 3);
            2:       return $urandom;
            default: return $urandom_range(0, 15);
        endcase
    endfunction

    task automatic queue_push();
        queue_instr(CMD_PUSH, 2'($urandom_range(0, 3)), 3'($urandom_range(0, 7)),
                    5'($urandom), 5'($urandom), 5'($urandom), pick_imm(), 10'($urandom));
    endtask

    task automatic queue_pop();
        queue_instr(CMD_POP, 2'($urandom_range(0, 3)), 3'($urandom_range(0, 7)),
                    5'($urandom), 5'($urandom), 5'($urandom), pick_imm(), 10'($urandom));
    endtask

    // push_pct: share of pushes among stack operations
    task automatic queue_random_instr(input int push_pct);
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 50) begin
            if ((($urandom_range(0, 99) < push_pct) && gen_depth < STACK_DEPTH) ||
                gen_depth == 0) begin
                queue_push();
            end else begin
                queue_pop();
            end
        end else if (pick < 88) begin
            queue_instr(CMD_SET, 2'($urandom_range(0, 3)), 3'($urandom_range(0, 7)),
                        5'($urandom), 5'($urandom), 5'($urandom), pick_imm(),
                        10'($urandom));
        end else begin
            queue_instr(CMD_GOTO, 2'($urandom_range(0, 3)), 3'($urandom_range(0, 7)),
                        5'($urandom), 5'($urandom), 5'($urandom), pick_imm(),
                        10'($urandom));
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
        if (exp_v !== act_v) begin
            if (errors < 10) begin
                $display("result %0d: %s expected 0x%0h, got 0x%0h",
                         results_seen, name, exp_v, act_v);
            end
            errors++;
        end
    endtask

    // stimulus
    initial begin
        int seg;
        int pct;
        // directed: wrap, extremes, every alu op, goto taken and not taken
        queue_instr(CMD_PUSH, MODE_IMM, ALU_ADD, 5'd0, 5'd0, 5'd0, 32'hFFFF_FFFF, 10'd0);
        queue_instr(CMD_PUSH, MODE_IMM, ALU_ADD, 5'd0, 5'd0, 5'd0, 32'h0, 10'd0);
        queue_instr(CMD_PUSH, MODE_COPY, ALU_ADD, 5'd0, 5'd0, 5'd0, 32'h0, 10'd0);
        queue_instr(CMD_POP, MODE_COPY, ALU_ADD, 5'd31, 5'd0, 5'd0, 32'h0, 10'd0);
        queue_instr(CMD_POP, MODE_COPY, ALU_ADD, 5'd0, 5'd0, 5'd0, 32'h0, 10'd0);
        queue_instr(CMD_POP, MODE_COPY, ALU_ADD, 5'd1, 5'd0, 5'd0, 32'h0, 10'd0);
        queue_instr(CMD_SET, MODE_IMM, ALU_ADD, 5'd2, 5'd0, 5'd0, 32'd1, 10'd0);
        queue_instr(CMD_SET, MODE_IMM, ALU_ADD, 5'd3, 5'd0, 5'd0, 32'h0000_FFFF, 10'd0);
        queue_instr(CMD_SET, MODE_REG_RR, ALU_ADD, 5'd4, 5'd1, 5'd2, 32'h0, 10'd0);
        queue_instr(CMD_SET, MODE_REG_RR, ALU_SUB, 5'd5, 5'd0, 5'd2, 32'h0, 10'd0);
        queue_instr(CMD_SET, MODE_REG_RI, ALU_EQ, 5'd6, 5'd2, 5'd0, 32'd1, 10'd0);
        queue_instr(CMD_SET, MODE_REG_RR, ALU_GT, 5'd7, 5'd1, 5'd3, 32'h0, 10'd0);
        queue_instr(CMD_SET, MODE_REG_RI, ALU_GTE, 5'd8, 5'd3, 5'd0, 32'd16, 10'd0);
        queue_instr(CMD_SET, MODE_REG_RR, ALU_LT, 5'd9, 5'd2, 5'd1, 32'h0, 10'd0);
        queue_instr(CMD_SET, MODE_REG_RI, ALU_LTE, 5'd10, 5'd1, 5'd0, 32'hFFFF_FFFF, 10'd0);
        queue_instr(CMD_SET, MODE_REG_RR, ALU_NONE, 5'd11, 5'd1, 5'd2, 32'h0, 10'd0);
        queue_instr(CMD_SET, MODE_REG_RI, ALU_NONE, 5'd12, 5'd1, 5'd0, 32'h5, 10'd0);
        queue_instr(CMD_SET, MODE_COPY, ALU_ADD, 5'd13, 5'd1, 5'd0, 32'h0, 10'd0);
        queue_instr(CMD_GOTO, MODE_COPY, ALU_ADD, 5'd0, 5'd0, 5'd0, 32'h0, 10'd5);
        queue_instr(CMD_GOTO, MODE_COPY, ALU_ADD, 5'd0, 5'd1, 5'd0, 32'h0, 10'd1023);
        queue_instr(CMD_GOTO, MODE_COPY, ALU_ADD, 5'd0, 5'd2, 5'd0, 32'h0, 10'd0);
        queue_instr(CMD_PUSH, MODE_REG_RI, ALU_ADD, 5'd0, 5'd1, 5'd0, 32'h0, 10'd0);
        queue_instr(CMD_PUSH, MODE_REG_RR, ALU_ADD, 5'd0, 5'd3, 5'd0, 32'h0, 10'd0);
        queue_instr(CMD_POP, MODE_COPY, ALU_ADD, 5'd14, 5'd0, 5'd0, 32'h0, 10'd0);
        queue_instr(CMD_POP, MODE_COPY, ALU_ADD, 5'd15, 5'd0, 5'd0, 32'h0, 10'd0);

        // fill the whole stack and drain it, random content throughout
        while (gen_depth < STACK_DEPTH) begin
            if ($urandom_range(0, 3) == 0) begin
                queue_random_instr(100);
            end else begin
                queue_push();
            end
        end
        while (gen_depth > 0) begin
            if ($urandom_range(0, 3) == 0) begin
                queue_random_instr(0);
            end else begin
                queue_pop();
            end
        end

        // random walk in segments of varying push bias
        while (instr_queue.size() < RANDOM_ITEMS) begin
            case ($urandom_range(0, 2))
                0:       pct = 20;
                1:       pct = 50;
                default: pct = 80;
            endcase
            seg = $urandom_range(40, 200);
            repeat (seg) queue_random_instr(pct);
        end

        // one stopping instruction ends the run, then ignored noise
        case ($urandom_range(0, 3))
            0: queue_instr(CMD_HALT, 2'($urandom), 3'($urandom), 5'($urandom),
                           5'($urandom), 5'($urandom), $urandom, 10'($urandom));
            1: queue_instr(3'($urandom_range(BAD_CMD_LO, BAD_CMD_HI)), 2'($urandom),
                           3'($urandom), 5'($urandom), 5'($urandom), 5'($urandom),
                           $urandom, 10'($urandom));
            2: begin
                while (gen_depth > 0) queue_pop();
                queue_pop();
            end
            default: begin
                while (gen_depth < STACK_DEPTH) queue_push();
                queue_push();
            end
        endcase
        repeat (20) begin
            queue_instr(3'($urandom), 2'($urandom), 3'($urandom), 5'($urandom),
                        5'($urandom), 5'($urandom), $urandom, 10'($urandom));
        end
        instr_total = instr_queue.size();

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        while (instrs_accepted < instr_total || expected_results.size() != 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN_WAIT) @(posedge aclk);
        if (errors == 0) begin
            $display("stack_register_instruction_executor regression: pass");
        end else begin
            $display("stack_register_instruction_executor regression: fail");
        end
        $finish;
    end

    // driver
    int send_gap = 0;
    always @(posedge aclk) begin
        logic nxt_valid;
        nxt_valid = 1'b0;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!(s_tvalid && !s_tready)) begin
            if (s_tvalid) begin
                void'(instr_queue.pop_front());
            end
            if (send_gap > 0) begin
                send_gap--;
            end else if (instr_queue.size() > QUIET_TAIL && $urandom_range(0, 9) == 0) begin
                send_gap = $urandom_range(1, 13) - 1;
            end else if (instr_queue.size() > 0) begin
                nxt_valid = 1'b1;
                s_tdata  <= instr_queue[0];
            end
            s_tvalid <= nxt_valid;
        end
    end

    // monitor: predict on each input transaction, check each output transaction
    int stall_cnt = 0;
    always @(posedge aclk) begin
        logic [M_TDATA_W-1:0] exp_word;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                expected_results.push_back(execute_instr(s_tdata));
                instrs_accepted++;
            end
            if (m_tvalid && m_tready) begin
                if (expected_results.size() == 0) begin
                    if (errors < 10) begin
                        $display("result %0d: unexpected transaction 0x%0h",
                                 results_seen, m_tdata);
                    end
                    errors++;
                end else begin
                    exp_word = expected_results.pop_front();
                    check_field("next_ip", 32'(exp_word[9:0]), 32'(m_tdata[9:0]));
                    check_field("status", 32'(exp_word[12:10]), 32'(m_tdata[12:10]));
                    check_field("reg_written", 32'(exp_word[13]), 32'(m_tdata[13]));
                    check_field("written_reg", 32'(exp_word[18:14]), 32'(m_tdata[18:14]));
                    check_field("written_value", exp_word[50:19], m_tdata[50:19]);
                    check_field("stack_depth", 32'(exp_word[59:51]), 32'(m_tdata[59:51]));
                end
                results_seen++;
            end
            if (stall_cnt > 0) begin
                stall_cnt--;
                m_tready <= 1'b0;
            end else if (instr_queue.size() > QUIET_TAIL && $urandom_range(0, 7) == 0) begin
                stall_cnt = $urandom_range(1, 13) - 1;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    initial begin
        #5ms;
        $display("stack_register_instruction_executor regression: fail");
        $finish;
    end

endmodule

`default_nettype wire

@@ sim.f @@
+incdir+rtl
rtl/srie_pkg.sv
rtl/srie_ram.sv
rtl/stack_register_instruction_executor.sv
dv/stack_register_instruction_executor_tb.sv
